[hw/rtl/rle_pkg.sv]
package rle_pkg;

  // Bit of a header byte that selects literal copy over run.
  localparam int LiteralBit = 7;
  localparam int CountBits  = 7;

  typedef struct packed {
    logic header;     // load count from a nonzero header
    logic end_row;    // emit end-of-row marker, clear row state
    logic literal;    // pass one literal byte or drop it
    logic run_start;  // capture run value and clamp run to room left
    logic run_emit;   // emit one beat of the run
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;     // output register empty or being taken
    logic hdr_zero;     // header count is zero
    logic hdr_literal;  // header selects literal copy
    logic rem_one;      // last literal byte of the packet
    logic take_zero;    // run has no room left
    logic run_last;     // current beat finishes the run
  } dp_status_t;

endpackage

[hw/rtl/rle_ctrl.sv]
module rle_ctrl
  import rle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_HEADER  = 2'd0,
    S_LITERAL = 2'd1,
    S_RUN     = 2'd2,
    S_EXPAND  = 2'd3
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_take;

  assign in_stall = (state == S_EXPAND) || !status.out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_HEADER: begin
        if (in_take) begin
          if (status.hdr_zero) begin
            cmd.end_row = 1'b1;
          end else begin
            cmd.header = 1'b1;
            state_next = status.hdr_literal ? S_LITERAL : S_RUN;
          end
        end
      end
      S_LITERAL: begin
        if (in_take) begin
          cmd.literal = 1'b1;
          if (status.rem_one) state_next = S_HEADER;
        end
      end
      S_RUN: begin
        if (in_take) begin
          cmd.run_start = 1'b1;
          state_next = status.take_zero ? S_HEADER : S_EXPAND;
        end
      end
      S_EXPAND: begin
        if (status.out_free) begin
          cmd.run_emit = 1'b1;
          if (status.run_last) state_next = S_HEADER;
        end
      end
      default: state_next = S_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_input_in_expand: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPAND) |-> in_stall)
    else $error("input taken during run expansion");
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.run_emit || cmd.end_row) |-> status.out_free)
    else $error("result loaded into a busy output register");
`endif

endmodule

[hw/rtl/rle_datapath.sv]
module rle_datapath
  import rle_pkg::*;
#(
  parameter int LANE_W = 4
)
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [7:0]  code_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  lane0,
  output logic [7:0]  lane1,
  output logic [7:0]  lane2,
  output logic [7:0]  lane3,
  output logic [2:0]  byte_count,
  output logic        row_end,
  output logic        overflow
);

  logic [15:0]          row_length;
  logic [CountBits-1:0] remaining;
  logic [15:0]          emitted;
  logic                 overflowed;
  logic [7:0]           run_byte;
  logic [CountBits-1:0] run_left;

  logic [15:0]          room;
  logic                 cut;
  logic [CountBits-1:0] take;
  logic                 has_room;
  logic [2:0]           beat_n;
  logic [7:0]           beat_lane [4];
  logic                 out_load;

  assign has_room = emitted < row_length;
  assign room     = has_room ? (row_length - emitted) : 16'd0;
  assign cut      = {{(16 - CountBits){1'b0}}, remaining} > room;
  assign take     = cut ? room[CountBits-1:0] : remaining;

  assign beat_n = (run_left < CountBits'(LANE_W)) ? run_left[2:0] : 3'(LANE_W);

  // a beat enters the output register on an end marker, a kept literal or a run beat
  assign out_load = cmd.end_row || cmd.run_emit || (cmd.literal && has_room);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      beat_lane[i] = (3'(i) < beat_n) ? run_byte : 8'd0;
    end
  end

  assign status.out_free    = !out_valid || !out_stall;
  assign status.hdr_zero    = (code_byte[CountBits-1:0] == '0);
  assign status.hdr_literal = code_byte[LiteralBit];
  assign status.rem_one     = (remaining == CountBits'(1));
  assign status.take_zero   = (take == '0);
  assign status.run_last    = (run_left <= CountBits'(LANE_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 16'hFFFF;
      remaining  <= '0;
      emitted    <= '0;
      overflowed <= 1'b0;
      run_left   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) row_length <= cfg_data;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (status.out_free) begin
        out_valid <= 1'b0;
      end

      if (cmd.header) begin
        remaining <= code_byte[CountBits-1:0];
      end

      if (cmd.end_row) begin
        lane0      <= 8'd0;
        lane1      <= 8'd0;
        lane2      <= 8'd0;
        lane3      <= 8'd0;
        byte_count <= 3'd0;
        row_end    <= 1'b1;
        overflow   <= overflowed;
        remaining  <= '0;
        emitted    <= '0;
        overflowed <= 1'b0;
      end

      if (cmd.literal) begin
        remaining <= remaining - CountBits'(1);
        if (has_room) begin
          emitted    <= emitted + 16'd1;
          lane0      <= code_byte;
          lane1      <= 8'd0;
          lane2      <= 8'd0;
          lane3      <= 8'd0;
          byte_count <= 3'd1;
          row_end    <= 1'b0;
          overflow   <= overflowed;
        end else begin
          overflowed <= 1'b1;
        end
      end

      if (cmd.run_start) begin
        if (cut) overflowed <= 1'b1;
        emitted   <= emitted + {{(16 - CountBits){1'b0}}, take};
        run_left  <= take;
        run_byte  <= code_byte;
        remaining <= '0;
      end

      if (cmd.run_emit) begin
        run_left   <= run_left - {{(CountBits - 3){1'b0}}, beat_n};
        lane0      <= beat_lane[0];
        lane1      <= beat_lane[1];
        lane2      <= beat_lane[2];
        lane3      <= beat_lane[3];
        byte_count <= beat_n;
        row_end    <= 1'b0;
        overflow   <= overflowed;
      end
    end
  end

endmodule

[hw/rtl/rle_row_decoder_top.sv]
// Run-length decoder for one image row: compressed bytes go in one per beat,
// decoded pixel bytes come out packed into up to LANES (clamped to 1..4) lanes
// per beat. A header or literal byte is taken on its own; a run value byte is
// then expanded into beats of up to that many bytes, during which in_stall
// stays high; a run with no room left in the row is not expanded. Each input
// byte causes at most one result outside expansion, and one output register
// holds the result until out_stall drops. A zero-count header ends the row
// with an empty beat marked row_end and clears the row state. Decoded bytes
// beyond row_length are dropped and flagged on overflow.
module rle_row_decoder_top
  import rle_pkg::*;
#(
  parameter int LANES = 4
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  lane0,
  output logic [7:0]  lane1,
  output logic [7:0]  lane2,
  output logic [7:0]  lane3,
  output logic [2:0]  byte_count,
  output logic        row_end,
  output logic        overflow
);

  localparam int LaneW = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rle_datapath #(
    .LANE_W (LaneW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .code_byte  (code_byte),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lane0      (lane0),
    .lane1      (lane1),
    .lane2      (lane2),
    .lane3      (lane3),
    .byte_count (byte_count),
    .row_end    (row_end),
    .overflow   (overflow)
  );

`ifndef SYNTHESIS
  a_empty_is_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (byte_count == 3'd0)) |-> row_end)
    else $error("empty beat without row_end");
  a_row_end_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && row_end) |->
      ((byte_count == 3'd0) && (lane0 == 8'd0) && (lane3 == 8'd0)))
    else $error("row_end beat carries data");
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count <= 3'(LaneW)))
    else $error("byte_count above lane width");
`endif

endmodule
